FILE: sv/bbi_pkg.sv
// bbi_pkg: shared types and constants of the bilinear block interpolator
// no dependencies; used by bilinear_block_interpolator

package bbi_pkg;

  localparam int CORNER_W  = 16;
  localparam int COORD_W   = 3;
  localparam int NUM_CH    = 3;
  localparam int NUM_DIV   = 3;
  // magnitude of a corner difference, wide enough for a - b - c + d
  localparam int DIFF_W    = 18;
  // log2 of the largest divisor, cell size squared
  localparam int DIV_GUARD = 6;

  localparam int CH_U   = 0;
  localparam int CH_V   = 1;
  localparam int CH_FOG = 2;

  localparam int DIV_COL   = 0;
  localparam int DIV_ROW   = 1;
  localparam int DIV_CROSS = 2;

  typedef logic [CORNER_W-1:0] corner_t;
  typedef logic [DIFF_W-1:0]   diff_mag_t;

endpackage

FILE: sv/bilinear_block_interpolator.sv
// bilinear_block_interpolator: fills one square cell per item by bilinear forward differencing
// depends on bbi_pkg
//
//   channel | ports                               | transfer when
//   input   | in_valid, in_stall, in_*_* corners  | in_valid && !in_stall
//   output  | out_valid, out_stall, out_* fields  | out_valid && !out_stall
//
// one cell gives CELL_SIZE*CELL_SIZE results, one per cycle from the pixel generator while out_stall is low
// the single pixel generator works on one cell at a time and loads the next item as it emits the last pixel
// an item passes step stages 1, 2 and 3 before the generator loads it; each pixel then goes to the output register
// the three step stages hold up to three more cells while the generator runs
// rst_n is synchronous and clears all valid bits; out_stall holds the output register
// and backs up through the generator and the step stages to in_stall

module bilinear_block_interpolator #(
  parameter int CELL_SIZE     = 8,
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_u_top_left,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_u_top_right,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_u_bottom_left,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_u_bottom_right,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_v_top_left,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_v_top_right,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_v_bottom_left,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_v_bottom_right,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_fog_top_left,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_fog_top_right,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_fog_bottom_left,
  input  logic [bbi_pkg::CORNER_W-1:0]   in_fog_bottom_right,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bbi_pkg::COORD_W-1:0]    out_column_in_cell,
  output logic [bbi_pkg::COORD_W-1:0]    out_row_in_cell,
  output logic [bbi_pkg::CORNER_W-1:0]   out_u_value,
  output logic [bbi_pkg::CORNER_W-1:0]   out_v_value,
  output logic [bbi_pkg::CORNER_W-1:0]   out_fog_value,
  output logic                           out_last_of_cell
);

  localparam int F   = FRACTION_BITS;
  localparam int YW  = bbi_pkg::DIFF_W;
  localparam int CW  = (CELL_SIZE > 1) ? $clog2(CELL_SIZE) : 1;
  // reciprocal scale, exact for numerators below 2^(YW+F) and divisors up to 2^DIV_GUARD
  localparam int K   = YW + F + bbi_pkg::DIV_GUARD;
  localparam int S   = K - F;
  localparam int MLO = K / 2;
  localparam int MHI = K - MLO;
  localparam int PW  = YW + K;
  localparam int QW  = YW + F;
  localparam int SW  = QW + 1;
  localparam int AW  = F + 23;
  localparam int NSQ = CELL_SIZE * CELL_SIZE;

  localparam logic [63:0] ONE64 = 64'd1;
  localparam logic [63:0] M_N   = ((ONE64 << K) + 64'(CELL_SIZE) - 64'd1) / 64'(CELL_SIZE);
  localparam logic [63:0] M_X   = ((ONE64 << K) + 64'(NSQ) - 64'd1) / 64'(NSQ);
  localparam logic [63:0] T_N   = ((ONE64 << S) + 64'(CELL_SIZE) - 64'd1) / 64'(CELL_SIZE);
  localparam logic [63:0] T_X   = ((ONE64 << S) + 64'(NSQ) - 64'd1) / 64'(NSQ);

  localparam logic [MLO-1:0] M_N_LO = M_N[MLO-1:0];
  localparam logic [MHI-1:0] M_N_HI = M_N[K-1:MLO];
  localparam logic [MLO-1:0] M_X_LO = M_X[MLO-1:0];
  localparam logic [MHI-1:0] M_X_HI = M_X[K-1:MLO];
  localparam logic [S-1:0]   THR_N  = T_N[S-1:0];
  localparam logic [S-1:0]   THR_X  = T_X[S-1:0];
  localparam logic [CW-1:0]  LAST_C = CW'(CELL_SIZE - 1);

  // corners per channel: top-left, top-right, bottom-left, bottom-right
  bbi_pkg::corner_t  corner [bbi_pkg::NUM_CH][4];

  // stage 1: signed corner differences as magnitude and sign
  logic              s1_valid_r;
  bbi_pkg::corner_t  s1_base_r  [bbi_pkg::NUM_CH];
  bbi_pkg::diff_mag_t s1_mag_r  [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic              s1_neg_r   [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  bbi_pkg::diff_mag_t s1_mag_nxt [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic              s1_neg_nxt [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];

  // stage 2: reciprocal partial products
  logic                s2_valid_r;
  bbi_pkg::corner_t    s2_base_r [bbi_pkg::NUM_CH];
  logic                s2_neg_r  [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic [YW+MLO-1:0]   s2_plo_r  [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic [YW+MHI-1:0]   s2_phi_r  [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic [YW+MLO-1:0]   s2_plo_nxt [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic [YW+MHI-1:0]   s2_phi_nxt [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];

  // stage 3: floor quotient of the magnitude and inexact flag
  logic                s3_valid_r;
  bbi_pkg::corner_t    s3_base_r [bbi_pkg::NUM_CH];
  logic                s3_neg_r  [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic [QW-1:0]       s3_q_r    [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic                s3_nx_r   [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic [QW-1:0]       s3_q_nxt  [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  logic                s3_nx_nxt [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];

  // pixel generator
  logic                gen_busy_r;
  logic [CW-1:0]       gen_col_r;
  logic [CW-1:0]       gen_row_r;
  logic signed [AW-1:0] gen_row_start_r [bbi_pkg::NUM_CH];
  logic signed [AW-1:0] gen_cur_r       [bbi_pkg::NUM_CH];
  logic signed [AW-1:0] gen_col_step_r  [bbi_pkg::NUM_CH];
  logic signed [AW-1:0] gen_row_step_r  [bbi_pkg::NUM_CH];
  logic signed [AW-1:0] gen_cross_r     [bbi_pkg::NUM_CH];
  logic signed [AW-1:0] gen_step_nxt    [bbi_pkg::NUM_CH][bbi_pkg::NUM_DIV];
  bbi_pkg::corner_t    gen_sat          [bbi_pkg::NUM_CH];

  // output register
  logic                out_valid_r;
  logic [CW-1:0]       out_col_r;
  logic [CW-1:0]       out_row_r;
  bbi_pkg::corner_t    out_value_r [bbi_pkg::NUM_CH];
  logic                out_last_r;

  logic out_free;
  logic gen_fire;
  logic gen_col_end;
  logic gen_at_last;
  logic gen_done;
  logic gen_load;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  // flow control
  always_comb begin
    out_free    = !out_valid_r || !out_stall;
    gen_fire    = gen_busy_r && out_free;
    gen_col_end = (gen_col_r == LAST_C);
    gen_at_last = gen_col_end && (gen_row_r == LAST_C);
    gen_done    = gen_fire && gen_at_last;
    gen_load    = s3_valid_r && (!gen_busy_r || gen_done);
    s3_ready    = !s3_valid_r || gen_load;
    s2_ready    = !s2_valid_r || s3_ready;
    s1_ready    = !s1_valid_r || s2_ready;
    in_stall    = !s1_ready;
  end

  always_comb begin
    corner[bbi_pkg::CH_U][0]   = in_u_top_left;
    corner[bbi_pkg::CH_U][1]   = in_u_top_right;
    corner[bbi_pkg::CH_U][2]   = in_u_bottom_left;
    corner[bbi_pkg::CH_U][3]   = in_u_bottom_right;
    corner[bbi_pkg::CH_V][0]   = in_v_top_left;
    corner[bbi_pkg::CH_V][1]   = in_v_top_right;
    corner[bbi_pkg::CH_V][2]   = in_v_bottom_left;
    corner[bbi_pkg::CH_V][3]   = in_v_bottom_right;
    corner[bbi_pkg::CH_FOG][0] = in_fog_top_left;
    corner[bbi_pkg::CH_FOG][1] = in_fog_top_right;
    corner[bbi_pkg::CH_FOG][2] = in_fog_bottom_left;
    corner[bbi_pkg::CH_FOG][3] = in_fog_bottom_right;
  end

  // stage 1 logic
  always_comb begin
    logic signed [YW-1:0] a, b, c, d;
    logic signed [YW-1:0] diff [bbi_pkg::NUM_DIV];
    for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
      a = $signed(YW'(corner[i][0]));
      b = $signed(YW'(corner[i][1]));
      c = $signed(YW'(corner[i][2]));
      d = $signed(YW'(corner[i][3]));
      diff[bbi_pkg::DIV_COL]   = b - a;
      diff[bbi_pkg::DIV_ROW]   = c - a;
      diff[bbi_pkg::DIV_CROSS] = a - b - c + d;
      for (int j = 0; j < bbi_pkg::NUM_DIV; j++) begin
        s1_neg_nxt[i][j] = diff[j][YW-1];
        s1_mag_nxt[i][j] = diff[j][YW-1] ? YW'(-diff[j]) : YW'(diff[j]);
      end
    end
  end

  // stage 2 logic: magnitude times split reciprocal
  always_comb begin
    logic [MLO-1:0] mlo;
    logic [MHI-1:0] mhi;
    for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
      for (int j = 0; j < bbi_pkg::NUM_DIV; j++) begin
        mlo = (j == bbi_pkg::DIV_CROSS) ? M_X_LO : M_N_LO;
        mhi = (j == bbi_pkg::DIV_CROSS) ? M_X_HI : M_N_HI;
        s2_plo_nxt[i][j] = (YW+MLO)'(s1_mag_r[i][j]) * (YW+MLO)'(mlo);
        s2_phi_nxt[i][j] = (YW+MHI)'(s1_mag_r[i][j]) * (YW+MHI)'(mhi);
      end
    end
  end

  // stage 3 logic: sum partial products, take quotient and remainder test
  always_comb begin
    logic [PW-1:0] full;
    logic [S-1:0]  thr;
    for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
      for (int j = 0; j < bbi_pkg::NUM_DIV; j++) begin
        thr  = (j == bbi_pkg::DIV_CROSS) ? THR_X : THR_N;
        full = {s2_phi_r[i][j], {MLO{1'b0}}} + PW'(s2_plo_r[i][j]);
        s3_q_nxt[i][j]  = full[PW-1:S];
        s3_nx_nxt[i][j] = (full[S-1:0] >= thr);
      end
    end
  end

  // signed floor steps at generator load
  always_comb begin
    logic signed [SW-1:0] qs;
    for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
      for (int j = 0; j < bbi_pkg::NUM_DIV; j++) begin
        qs = $signed({1'b0, s3_q_r[i][j]});
        if (s3_neg_r[i][j]) begin
          gen_step_nxt[i][j] = AW'(-(qs + SW'(s3_nx_r[i][j])));
        end else begin
          gen_step_nxt[i][j] = AW'(qs);
        end
      end
    end
  end

  // clamp to 0..65535
  always_comb begin
    for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
      if (gen_cur_r[i][AW-1]) begin
        gen_sat[i] = '0;
      end else if (|gen_cur_r[i][AW-2:F+bbi_pkg::CORNER_W]) begin
        gen_sat[i] = '1;
      end else begin
        gen_sat[i] = gen_cur_r[i][F+bbi_pkg::CORNER_W-1:F];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      gen_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (gen_load) begin
        gen_busy_r <= 1'b1;
      end else if (gen_done) begin
        gen_busy_r <= 1'b0;
      end
      if (gen_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // step pipeline payload
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
        s1_base_r[i] <= corner[i][0];
        for (int j = 0; j < bbi_pkg::NUM_DIV; j++) begin
          s1_mag_r[i][j] <= s1_mag_nxt[i][j];
          s1_neg_r[i][j] <= s1_neg_nxt[i][j];
        end
      end
    end
    if (s2_ready) begin
      for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
        s2_base_r[i] <= s1_base_r[i];
        for (int j = 0; j < bbi_pkg::NUM_DIV; j++) begin
          s2_neg_r[i][j] <= s1_neg_r[i][j];
          s2_plo_r[i][j] <= s2_plo_nxt[i][j];
          s2_phi_r[i][j] <= s2_phi_nxt[i][j];
        end
      end
    end
    if (s3_ready) begin
      for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
        s3_base_r[i] <= s2_base_r[i];
        for (int j = 0; j < bbi_pkg::NUM_DIV; j++) begin
          s3_neg_r[i][j] <= s2_neg_r[i][j];
          s3_q_r[i][j]   <= s3_q_nxt[i][j];
          s3_nx_r[i][j]  <= s3_nx_nxt[i][j];
        end
      end
    end
  end

  // generator and output payload
  always_ff @(posedge clk) begin
    if (gen_load) begin
      gen_col_r <= '0;
      gen_row_r <= '0;
      for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
        gen_row_start_r[i] <= $signed(AW'({s3_base_r[i], {F{1'b0}}}));
        gen_cur_r[i]       <= $signed(AW'({s3_base_r[i], {F{1'b0}}}));
        gen_col_step_r[i]  <= gen_step_nxt[i][bbi_pkg::DIV_COL];
        gen_row_step_r[i]  <= gen_step_nxt[i][bbi_pkg::DIV_ROW];
        gen_cross_r[i]     <= gen_step_nxt[i][bbi_pkg::DIV_CROSS];
      end
    end else if (gen_fire) begin
      if (gen_col_end) begin
        gen_col_r <= '0;
        gen_row_r <= gen_row_r + CW'(1);
        for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
          gen_row_start_r[i] <= gen_row_start_r[i] + gen_row_step_r[i];
          gen_cur_r[i]       <= gen_row_start_r[i] + gen_row_step_r[i];
          gen_col_step_r[i]  <= gen_col_step_r[i] + gen_cross_r[i];
        end
      end else begin
        gen_col_r <= gen_col_r + CW'(1);
        for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
          gen_cur_r[i] <= gen_cur_r[i] + gen_col_step_r[i];
        end
      end
    end
    if (gen_fire) begin
      out_col_r  <= gen_col_r;
      out_row_r  <= gen_row_r;
      out_last_r <= gen_at_last;
      for (int i = 0; i < bbi_pkg::NUM_CH; i++) begin
        out_value_r[i] <= gen_sat[i];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_column_in_cell = bbi_pkg::COORD_W'(out_col_r);
  assign out_row_in_cell    = bbi_pkg::COORD_W'(out_row_r);
  assign out_u_value        = out_value_r[bbi_pkg::CH_U];
  assign out_v_value        = out_value_r[bbi_pkg::CH_V];
  assign out_fog_value      = out_value_r[bbi_pkg::CH_FOG];
  assign out_last_of_cell   = out_last_r;

  // a pixel that is not the last leaves the generator still holding its cell
  a_nonlast_gen_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> gen_busy_r)
    else $error("non-last pixel waiting with idle generator");

  // the last mark sits only on the bottom-right pixel
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_col_r == LAST_C && out_row_r == LAST_C))
    else $error("last mark off the bottom-right pixel");

  // a new cell starts at the top-left pixel
  a_load_origin: assert property (@(posedge clk) disable iff (!rst_n)
    gen_load |=> (gen_busy_r && gen_col_r == '0 && gen_row_r == '0))
    else $error("generator not at cell origin after load");

  // consecutive pixels of a cell follow in row-major order
  a_raster_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_last_r) |=>
      (!out_valid_r ||
       (out_row_r == $past(out_row_r) && out_col_r == $past(out_col_r) + CW'(1)) ||
       (out_col_r == '0 && out_row_r == $past(out_row_r) + CW'(1))))
    else $error("pixel order broken");

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: self-checking bench for bilinear_block_interpolator, one 8x8 cell per transfer
// a table of directed cells, then random bursts, each pixel checked against a local model or a given flat value
// depends on bbi_pkg and bilinear_block_interpolator
`timescale 1ns / 1ps

module tb_top;

  localparam int CELL_SIZE      = 8;
  localparam int FRAC_BITS      = 8;
  localparam int CELL_SHIFT     = 3;
  localparam int NUM_CORNERS    = 4 * bbi_pkg::NUM_CH;
  localparam int TL             = 0;
  localparam int TR             = 1;
  localparam int BL             = 2;
  localparam int BR             = 3;
  localparam int DIRECTED_ROWS  = 11;
  localparam int RANDOM_CELLS   = 260;
  localparam int HOLDOFF_START  = 40;
  localparam int HOLDOFF_CYCLES = 800;
  localparam int DRAIN_CYCLES   = 300;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int USE_MODEL      = -1;

  typedef bbi_pkg::corner_t [NUM_CORNERS-1:0] cell_t;

  typedef struct packed {
    logic [bbi_pkg::COORD_W-1:0] column;
    logic [bbi_pkg::COORD_W-1:0] row;
    bbi_pkg::corner_t            u;
    bbi_pkg::corner_t            v;
    bbi_pkg::corner_t            fog;
    logic                        last;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  bbi_pkg::corner_t in_u_top_left, in_u_top_right, in_u_bottom_left, in_u_bottom_right;
  bbi_pkg::corner_t in_v_top_left, in_v_top_right, in_v_bottom_left, in_v_bottom_right;
  bbi_pkg::corner_t in_fog_top_left, in_fog_top_right, in_fog_bottom_left;
  bbi_pkg::corner_t in_fog_bottom_right;
  logic out_valid;
  logic out_stall;
  logic [bbi_pkg::COORD_W-1:0] out_column_in_cell;
  logic [bbi_pkg::COORD_W-1:0] out_row_in_cell;
  bbi_pkg::corner_t out_u_value;
  bbi_pkg::corner_t out_v_value;
  bbi_pkg::corner_t out_fog_value;
  logic out_last_of_cell;

  pixel_t pending_pixels[$];
  int cells_sent;
  int pixels_checked = 0;
  int error_count = 0;
  int cycle_count = 0;
  bit holdoff_done = 1'b0;

  // corners per row: u tl, tr, bl, br, then v, then fog
  bbi_pkg::corner_t directed_corners [DIRECTED_ROWS][NUM_CORNERS] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'hABCD, 16'hABCD, 16'hABCD, 16'hABCD,
      16'h8000, 16'h8000, 16'h8000, 16'h8000},
    '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
      16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000},
    '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
      16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'hFFFF, 16'h0000},
    '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
      16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
      16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF},
    '{16'd100, 16'd101, 16'd102, 16'd103, 16'h0001, 16'h0000, 16'h0000, 16'h0001,
      16'h0000, 16'h0001, 16'h0001, 16'h0000},
    '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE, 16'h0002, 16'hFFFD,
      16'hFF00, 16'h00FF, 16'h0F0F, 16'hF0F0},
    '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE,
      16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF}
  };

  // flat cells: every pixel of a channel carries the given value; USE_MODEL rows are checked against the model
  int directed_expect [DIRECTED_ROWS][bbi_pkg::NUM_CH] = '{
    '{0, 0, 0},
    '{65535, 65535, 65535},
    '{16'h1234, 16'hABCD, 16'h8000},
    '{USE_MODEL, USE_MODEL, USE_MODEL},
    '{USE_MODEL, USE_MODEL, USE_MODEL},
    '{USE_MODEL, USE_MODEL, USE_MODEL},
    '{USE_MODEL, USE_MODEL, USE_MODEL},
    '{USE_MODEL, USE_MODEL, USE_MODEL},
    '{USE_MODEL, USE_MODEL, USE_MODEL},
    '{USE_MODEL, USE_MODEL, USE_MODEL},
    '{16'h0001, 16'hFFFE, 16'h00FF}
  };

  bilinear_block_interpolator #(
    .CELL_SIZE    (CELL_SIZE),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_u_top_left      (in_u_top_left),
    .in_u_top_right     (in_u_top_right),
    .in_u_bottom_left   (in_u_bottom_left),
    .in_u_bottom_right  (in_u_bottom_right),
    .in_v_top_left      (in_v_top_left),
    .in_v_top_right     (in_v_top_right),
    .in_v_bottom_left   (in_v_bottom_left),
    .in_v_bottom_right  (in_v_bottom_right),
    .in_fog_top_left    (in_fog_top_left),
    .in_fog_top_right   (in_fog_top_right),
    .in_fog_bottom_left (in_fog_bottom_left),
    .in_fog_bottom_right(in_fog_bottom_right),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_column_in_cell (out_column_in_cell),
    .out_row_in_cell    (out_row_in_cell),
    .out_u_value        (out_u_value),
    .out_v_value        (out_v_value),
    .out_fog_value      (out_fog_value),
    .out_last_of_cell   (out_last_of_cell)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // forward differencing per channel, cell size is a power of two so floor is a shift
  function automatic void fill_cell_pixels(cell_t c);
    longint row_start [bbi_pkg::NUM_CH];
    longint cur [bbi_pkg::NUM_CH];
    longint col_step [bbi_pkg::NUM_CH];
    longint row_step [bbi_pkg::NUM_CH];
    longint cross_step [bbi_pkg::NUM_CH];
    longint a, b, cl, d;
    bbi_pkg::corner_t val [bbi_pkg::NUM_CH];
    pixel_t px;
    for (int ch = 0; ch < bbi_pkg::NUM_CH; ch++) begin
      a = c[4*ch+TL];
      b = c[4*ch+TR];
      cl = c[4*ch+BL];
      d = c[4*ch+BR];
      row_start[ch] = a <<< FRAC_BITS;
      col_step[ch] = ((b - a) <<< FRAC_BITS) >>> CELL_SHIFT;
      row_step[ch] = ((cl - a) <<< FRAC_BITS) >>> CELL_SHIFT;
      cross_step[ch] = ((a - b - cl + d) <<< FRAC_BITS) >>> (2 * CELL_SHIFT);
    end
    for (int y = 0; y < CELL_SIZE; y++) begin
      for (int ch = 0; ch < bbi_pkg::NUM_CH; ch++) cur[ch] = row_start[ch];
      for (int x = 0; x < CELL_SIZE; x++) begin
        for (int ch = 0; ch < bbi_pkg::NUM_CH; ch++) begin
          if (cur[ch] < 0) val[ch] = '0;
          else if ((cur[ch] >>> FRAC_BITS) > 65535) val[ch] = '1;
          else val[ch] = bbi_pkg::corner_t'(cur[ch] >>> FRAC_BITS);
          cur[ch] += col_step[ch];
        end
        px.column = bbi_pkg::COORD_W'(x);
        px.row = bbi_pkg::COORD_W'(y);
        px.u = val[bbi_pkg::CH_U];
        px.v = val[bbi_pkg::CH_V];
        px.fog = val[bbi_pkg::CH_FOG];
        px.last = (x == CELL_SIZE - 1) && (y == CELL_SIZE - 1);
        pending_pixels.push_back(px);
      end
      for (int ch = 0; ch < bbi_pkg::NUM_CH; ch++) begin
        row_start[ch] += row_step[ch];
        col_step[ch] += cross_step[ch];
      end
    end
  endfunction

  function automatic void fill_flat_cell(bbi_pkg::corner_t u, bbi_pkg::corner_t v,
                                         bbi_pkg::corner_t fog);
    pixel_t px;
    for (int y = 0; y < CELL_SIZE; y++) begin
      for (int x = 0; x < CELL_SIZE; x++) begin
        px.column = bbi_pkg::COORD_W'(x);
        px.row = bbi_pkg::COORD_W'(y);
        px.u = u;
        px.v = v;
        px.fog = fog;
        px.last = (x == CELL_SIZE - 1) && (y == CELL_SIZE - 1);
        pending_pixels.push_back(px);
      end
    end
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int kind;
    int delta;
    bbi_pkg::corner_t base;
    kind = $urandom_range(0, 3);
    base = bbi_pkg::corner_t'($urandom_range(0, 65535));
    for (int k = 0; k < NUM_CORNERS; k++) begin
      case (kind)
        0: c[k] = bbi_pkg::corner_t'($urandom_range(0, 65535));
        1: begin
          case ($urandom_range(0, 2))
            0: c[k] = '0;
            1: c[k] = '1;
            default: c[k] = bbi_pkg::corner_t'($urandom_range(0, 65535));
          endcase
        end
        2: begin
          delta = int'(base) + int'($urandom_range(0, 64)) - 32;
          if (delta < 0) c[k] = '0;
          else if (delta > 65535) c[k] = '1;
          else c[k] = bbi_pkg::corner_t'(delta);
        end
        default: c[k] = base ^ (bbi_pkg::corner_t'(1) << $urandom_range(0, 15));
      endcase
    end
    return c;
  endfunction

  task automatic send_cell(cell_t c, int directed_row);
    @(negedge clk);
    in_valid <= 1'b1;
    in_u_top_left <= c[TL];
    in_u_top_right <= c[TR];
    in_u_bottom_left <= c[BL];
    in_u_bottom_right <= c[BR];
    in_v_top_left <= c[4+TL];
    in_v_top_right <= c[4+TR];
    in_v_bottom_left <= c[4+BL];
    in_v_bottom_right <= c[4+BR];
    in_fog_top_left <= c[8+TL];
    in_fog_top_right <= c[8+TR];
    in_fog_bottom_left <= c[8+BL];
    in_fog_bottom_right <= c[8+BR];
    do @(posedge clk); while (in_stall !== 1'b0);
    cells_sent++;
    if (directed_row >= 0 &&
        directed_expect[directed_row][bbi_pkg::CH_U] != USE_MODEL) begin
      fill_flat_cell(bbi_pkg::corner_t'(directed_expect[directed_row][bbi_pkg::CH_U]),
                     bbi_pkg::corner_t'(directed_expect[directed_row][bbi_pkg::CH_V]),
                     bbi_pkg::corner_t'(directed_expect[directed_row][bbi_pkg::CH_FOG]));
    end else begin
      fill_cell_pixels(c);
    end
  endtask

  task automatic hold_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic note_error(string what, pixel_t want, pixel_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%s at cycle %0d: expected col %0d row %0d u %h v %h fog %h last %b",
               what, cycle_count, want.column, want.row, want.u, want.v, want.fog, want.last);
      $display("    got col %0d row %0d u %h v %h fog %h last %b",
               got.column, got.row, got.u, got.v, got.fog, got.last);
    end
  endtask

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_column_in_cell, out_row_in_cell, out_u_value, out_v_value,
             out_fog_value, out_last_of_cell};
      if (pending_pixels.size() == 0) begin
        note_error("unexpected pixel", '0, got);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got.column !== want.column || got.row !== want.row || got.u !== want.u ||
            got.v !== want.v || got.fog !== want.fog || got.last !== want.last) begin
          note_error("pixel mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d pixels outstanding", pending_pixels.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver stall patterns, with one long hold-off once the pipe has traffic
  initial begin
    int mode;
    int span;
    int beat;
    out_stall = 1'b0;
    beat = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        beat++;
        if (!holdoff_done && cells_sent >= HOLDOFF_START) begin
          holdoff_done = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((beat % 5) < 2);
          endcase
        end
      end
    end
  end

  initial begin
    cell_t c;
    int burst;
    int random_sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_u_top_left, in_u_top_right, in_u_bottom_left, in_u_bottom_right} = '0;
    {in_v_top_left, in_v_top_right, in_v_bottom_left, in_v_bottom_right} = '0;
    {in_fog_top_left, in_fog_top_right, in_fog_bottom_left, in_fog_bottom_right} = '0;
    cells_sent = 0;
    random_sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      for (int k = 0; k < NUM_CORNERS; k++) c[k] = directed_corners[r][k];
      send_cell(c, r);
      if ($urandom_range(0, 2) == 0) hold_input($urandom_range(1, 6));
    end
    wait_drained();

    while (random_sent < RANDOM_CELLS) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && random_sent < RANDOM_CELLS; i++) begin
        send_cell(random_cell(), USE_MODEL);
        random_sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_input($urandom_range(1, 24));
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("cells sent %0d (%0d directed), pixels checked %0d, mismatches %0d",
             cells_sent, DIRECTED_ROWS, pixels_checked, error_count);
    $display("covered corner extremes, flat and saddle cells, bursty input, long output hold-off");
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: bilinear_block_interpolator.f
sv/bbi_pkg.sv
sv/bilinear_block_interpolator.sv
tb/sv/tb_top.sv
